/* hw/rtl/pwc_pkg.sv */
// Shared types, codes and helpers for the power window controller.
// No dependencies; used by pwc_step and power_window_controller_top.
package pwc_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [TICK_W-1:0] HOLD_TICKS_RST = TICK_W'(1000);
  localparam logic [TICK_W-1:0] JAM_TICKS_RST  = TICK_W'(2000);
  localparam logic [TICK_W-1:0] TICK_MAX       = {TICK_W{1'b1}};
  localparam logic [TICK_W-1:0] TICK_ONE       = TICK_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_JAM_TICKS  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } motor_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_HOLD   = 6'b000010,
    PH_MANUAL = 6'b000100,
    PH_AUTO   = 6'b001000,
    PH_WAIT   = 6'b010000,
    PH_JAM    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic driver_open_pressed;
    logic driver_close_pressed;
    logic passenger_open_pressed;
    logic passenger_close_pressed;
    logic open_limit_hit;
    logic closed_limit_hit;
    logic lock_engaged;
    logic jam_level;
  } pwc_in_t;

  typedef struct packed {
    phase_t            phase;
    logic              moving_closed;
    logic              from_passenger;
    logic [TICK_W-1:0] tick_count;
    logic              last_jam_level;
  } pwc_state_t;

  typedef struct packed {
    logic [1:0] motor_command;
    logic       lock_lamp;
  } pwc_res_t;

  function automatic logic [TICK_W-1:0] sat_inc(input logic [TICK_W-1:0] v);
    return (v == TICK_MAX) ? TICK_MAX : v + TICK_ONE;
  endfunction

endpackage

/* hw/rtl/pwc_step.sv */
// Next-state and result logic for one tick of the window controller.
// Purely combinational; depends on pwc_pkg.
module pwc_step (
  input  pwc_pkg::pwc_in_t              in_bits,
  input  pwc_pkg::pwc_state_t           state_i,
  input  logic [pwc_pkg::TICK_W-1:0]    hold_ticks,
  input  logic [pwc_pkg::TICK_W-1:0]    jam_ticks,
  output pwc_pkg::pwc_state_t           state_o,
  output pwc_pkg::pwc_res_t             res
);

  logic                       jam_edge;
  logic [pwc_pkg::TICK_W-1:0] hold_lim;
  logic [pwc_pkg::TICK_W-1:0] jam_lim;
  logic                       pan_open;
  logic                       pan_close;
  logic                       mine;
  logic                       other;
  logic                       limit;

  assign jam_edge  = state_i.last_jam_level && !in_bits.jam_level;
  assign hold_lim  = (hold_ticks == '0) ? pwc_pkg::TICK_ONE : hold_ticks;
  assign jam_lim   = (jam_ticks == '0) ? pwc_pkg::TICK_ONE : jam_ticks;
  assign pan_open  = state_i.from_passenger ? in_bits.passenger_open_pressed
                                            : in_bits.driver_open_pressed;
  assign pan_close = state_i.from_passenger ? in_bits.passenger_close_pressed
                                            : in_bits.driver_close_pressed;
  assign mine      = state_i.moving_closed ? pan_close : pan_open;
  assign other     = state_i.moving_closed ? pan_open : pan_close;
  assign limit     = state_i.moving_closed ? in_bits.closed_limit_hit
                                           : in_bits.open_limit_hit;

  always_comb begin
    state_o                = state_i;
    state_o.last_jam_level = in_bits.jam_level;
    if (jam_edge) begin
      state_o.phase      = pwc_pkg::PH_JAM;
      state_o.tick_count = pwc_pkg::TICK_ONE;
    end else begin
      unique case (state_i.phase)
        pwc_pkg::PH_IDLE: begin
          // driver first, open before close; lock gates passenger only
          if (in_bits.driver_open_pressed && !in_bits.open_limit_hit) begin
            state_o.phase          = pwc_pkg::PH_HOLD;
            state_o.from_passenger = 1'b0;
            state_o.moving_closed  = 1'b0;
            state_o.tick_count     = pwc_pkg::TICK_ONE;
          end else if (in_bits.driver_close_pressed && !in_bits.closed_limit_hit) begin
            state_o.phase          = pwc_pkg::PH_HOLD;
            state_o.from_passenger = 1'b0;
            state_o.moving_closed  = 1'b1;
            state_o.tick_count     = pwc_pkg::TICK_ONE;
          end else if (!in_bits.lock_engaged && in_bits.passenger_open_pressed &&
                       !in_bits.open_limit_hit) begin
            state_o.phase          = pwc_pkg::PH_HOLD;
            state_o.from_passenger = 1'b1;
            state_o.moving_closed  = 1'b0;
            state_o.tick_count     = pwc_pkg::TICK_ONE;
          end else if (!in_bits.lock_engaged && in_bits.passenger_close_pressed &&
                       !in_bits.closed_limit_hit) begin
            state_o.phase          = pwc_pkg::PH_HOLD;
            state_o.from_passenger = 1'b1;
            state_o.moving_closed  = 1'b1;
            state_o.tick_count     = pwc_pkg::TICK_ONE;
          end
        end
        pwc_pkg::PH_HOLD: begin
          if (limit || other) begin
            state_o.phase = pwc_pkg::PH_WAIT;
          end else if (state_i.tick_count >= hold_lim) begin
            state_o.phase = mine ? pwc_pkg::PH_MANUAL : pwc_pkg::PH_AUTO;
          end else begin
            state_o.tick_count = pwc_pkg::sat_inc(state_i.tick_count);
          end
        end
        pwc_pkg::PH_MANUAL: begin
          if (limit || !mine || other) state_o.phase = pwc_pkg::PH_WAIT;
        end
        pwc_pkg::PH_AUTO: begin
          if (limit || mine || other) state_o.phase = pwc_pkg::PH_WAIT;
        end
        pwc_pkg::PH_WAIT: begin
          if (!pan_open && !pan_close) state_o.phase = pwc_pkg::PH_IDLE;
        end
        pwc_pkg::PH_JAM: begin
          if (state_i.tick_count >= jam_lim) begin
            state_o.phase = pwc_pkg::PH_IDLE;
          end else begin
            state_o.tick_count = pwc_pkg::sat_inc(state_i.tick_count);
          end
        end
        default: state_o.phase = pwc_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    res.lock_lamp = in_bits.lock_engaged;
    case (state_o.phase)
      pwc_pkg::PH_HOLD, pwc_pkg::PH_MANUAL, pwc_pkg::PH_AUTO: begin
        res.motor_command = state_o.moving_closed ? pwc_pkg::MOTOR_CLOSE
                                                  : pwc_pkg::MOTOR_OPEN;
      end
      pwc_pkg::PH_JAM: res.motor_command = pwc_pkg::MOTOR_OPEN;
      default:         res.motor_command = pwc_pkg::MOTOR_STOP;
    endcase
  end

endmodule

/* hw/rtl/power_window_controller_top.sv */
// Power window controller top: config registers, state, output register + skid.
// Depends on pwc_pkg and pwc_step.
//
// A result is registered in the output register, or in the skid when out_* is stalled.
// One beat per cycle while in_ready is high; the state loop runs through state_r.
// A two-entry output stage (output register plus skid) keeps in_ready high while
// one result waits; in_ready drops only when both entries are full.
// Reset (rst_n low, synchronous): phase idle, tick count 0, last jam level 1,
// hold_ticks 1000, jam_ticks 2000, output stage empty. No clearing pass.
module power_window_controller_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_driver_open_pressed,
  input  logic                          in_driver_close_pressed,
  input  logic                          in_passenger_open_pressed,
  input  logic                          in_passenger_close_pressed,
  input  logic                          in_open_limit_hit,
  input  logic                          in_closed_limit_hit,
  input  logic                          in_lock_engaged,
  input  logic                          in_jam_level,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_motor_command,
  output logic                          out_lock_lamp,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pwc_pkg::TICK_W-1:0]    cfg_data
);

  logic [pwc_pkg::TICK_W-1:0] hold_ticks_r;
  logic [pwc_pkg::TICK_W-1:0] jam_ticks_r;
  pwc_pkg::pwc_state_t        state_r;
  pwc_pkg::pwc_state_t        state_nxt;
  pwc_pkg::pwc_in_t           in_bits;
  pwc_pkg::pwc_res_t          res_nxt;
  pwc_pkg::pwc_res_t          out_r;
  pwc_pkg::pwc_res_t          skid_r;
  logic                       out_valid_r;
  logic                       skid_valid_r;
  logic                       in_fire;
  logic                       out_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;

  assign in_bits = '{
    driver_open_pressed:     in_driver_open_pressed,
    driver_close_pressed:    in_driver_close_pressed,
    passenger_open_pressed:  in_passenger_open_pressed,
    passenger_close_pressed: in_passenger_close_pressed,
    open_limit_hit:          in_open_limit_hit,
    closed_limit_hit:        in_closed_limit_hit,
    lock_engaged:            in_lock_engaged,
    jam_level:               in_jam_level
  };

  pwc_step u_step (
    .in_bits    (in_bits),
    .state_i    (state_r),
    .hold_ticks (hold_ticks_r),
    .jam_ticks  (jam_ticks_r),
    .state_o    (state_nxt),
    .res        (res_nxt)
  );

  // config registers; writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= pwc_pkg::HOLD_TICKS_RST;
      jam_ticks_r  <= pwc_pkg::JAM_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == pwc_pkg::CFG_HOLD_TICKS) hold_ticks_r <= cfg_data;
      if (cfg_index == pwc_pkg::CFG_JAM_TICKS)  jam_ticks_r  <= cfg_data;
    end
  end

  // controller state advances once per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= pwc_pkg::PH_IDLE;
      state_r.moving_closed  <= 1'b0;
      state_r.from_passenger <= 1'b0;
      state_r.tick_count     <= '0;
      state_r.last_jam_level <= 1'b1;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // output stage: skid fills only when a new result arrives behind a stalled one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_ready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (in_fire) out_r <= res_nxt;
    end else if (in_fire) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_motor_command = out_r.motor_command;
  assign out_lock_lamp     = out_r.lock_lamp;

  // skid never holds a beat while the output register is empty
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result with output register empty");

  // a beat taken behind a stalled result lands in the skid
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("result lost behind stalled output");

  // a falling jam edge always restarts the jam timer
  a_jam_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r.last_jam_level && !in_jam_level) |=>
      (state_r.phase == pwc_pkg::PH_JAM && state_r.tick_count == pwc_pkg::TICK_ONE))
    else $error("jam edge did not start jam phase");

  // timed phases always run with a nonzero tick count
  a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == pwc_pkg::PH_JAM || state_r.phase == pwc_pkg::PH_HOLD) |->
      (state_r.tick_count != '0))
    else $error("timed phase with zero tick count");

  // output valid drops once the last pending result drains and no new beat is taken
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !skid_valid_r && !in_fire) |=> !out_valid_r)
    else $error("output valid without a pending result");

endmodule
